>>> hdl/wvs_pkg.sv
// Shared types, codes and constants of the weighted voxel sampler.
package wvs_pkg;

	localparam int DEF_MAX_VOXELS  = 4096;
	localparam int DEF_WEIGHT_BITS = 32;

	localparam int ACT_W   = 2;
	localparam int COORD_W = 12;
	localparam int GRID_W  = 13;
	localparam int WIN_W   = 32;
	localparam int RAND_W  = 32;
	localparam int VOX_W   = 12;
	localparam int TOTAL_W = 44;
	localparam int STAT_W  = 2;
	localparam int CIDX_W  = 2;
	localparam int ESEL_W  = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// actions
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_BUILD  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOTBUILT = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_GRID_X = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_GRID_Y = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_GRID_Z = 2'd2;

	// result word selection
	localparam logic [ESEL_W-1:0] EM_PLAIN    = 2'd0;
	localparam logic [ESEL_W-1:0] EM_LOAD     = 2'd1;
	localparam logic [ESEL_W-1:0] EM_NOTBUILT = 2'd2;
	localparam logic [ESEL_W-1:0] EM_SAMPLE   = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [COORD_W-1:0] voxel_x;
		logic [COORD_W-1:0] voxel_y;
		logic [COORD_W-1:0] voxel_z;
		logic [WIN_W-1:0]   weight;
		logic [RAND_W-1:0]  random_fraction;
	} item_t;

	typedef struct packed {
		logic [VOX_W-1:0]   chosen_voxel;
		logic [TOTAL_W-1:0] total_weight;
		logic [STAT_W-1:0]  status;
	} result_t;

	typedef struct packed {
		logic [GRID_W-1:0] grid_x;
		logic [GRID_W-1:0] grid_y;
		logic [GRID_W-1:0] grid_z;
	} grid_cfg_t;

	typedef struct packed {
		logic              cap;
		logic              cnt_zero;
		logic              clr_step;
		logic              unbuild;
		logic              n_mul1;
		logic              n_mul2;
		logic              bld_step;
		logic              bld_fin;
		logic              ld_mul1;
		logic              ld_mul2;
		logic              ld_wr;
		logic              smp_mul1;
		logic              smp_mul2;
		logic              srch_cmp;
		logic              emit;
		logic [ESEL_W-1:0] emit_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic walk_done;
		logic smp_ok;
		logic srch_done;
	} ctl_sts_t;

endpackage

>>> hdl/weighted_voxel_sampler_unit.sv
// Top level of the weighted voxel sampler: grid registers, controller and datapath.
//
// Weighted voxel sampler. A command word is taken when start is high and busy is low;
// each command gives exactly one result word, shown for one cycle with done high in the
// cycle that busy drops. The receiver cannot stall, so capture the word when done is
// seen. Clear is bounded by sweeping one weight entry per cycle through the single write
// port; build by the one-entry-per-cycle walk of the weight store over the voxels in
// use (capped at MAX_VOXELS); sample by the binary search, one cumulative-store read
// and one compare per step; a sample with no table built ends without a search. After
// reset the block stays busy while the weight store is zeroed; grid registers can be
// written during that pass. Otherwise the user must write grid registers only while no
// command is in flight; the block itself does not enforce this. cfg_ready is always high.
module weighted_voxel_sampler_unit import wvs_pkg::*; #(
	parameter int MAX_VOXELS  = DEF_MAX_VOXELS,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              done,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [GRID_W-1:0] cfg_data
);

	grid_cfg_t grid_q;
	ctl_cmd_t  cmd;
	ctl_sts_t  sts;

	assign cfg_ready = 1'b1;

	// grid size registers; an index past grid_z is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q.grid_x <= GRID_W'(1);
			grid_q.grid_y <= GRID_W'(1);
			grid_q.grid_z <= GRID_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_X: grid_q.grid_x <= cfg_data;
				CFG_GRID_Y: grid_q.grid_y <= cfg_data;
				CFG_GRID_Z: grid_q.grid_z <= cfg_data;
				default: ;
			endcase
		end
	end

	wvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	wvs_datapath #(
		.MAX_VOXELS  (MAX_VOXELS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.grid   (grid_q),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

`ifndef ASSERT_OFF
	// an accepted command leaves the block busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted but block not busy");

	// the result word comes out only after the controller is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// any failed command reports voxel zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.chosen_voxel == '0))
		else $error("nonzero voxel on failed command");
`endif

endmodule

>>> hdl/wvs_ctrl.sv
// Sequencing state machine of the weighted voxel sampler.
module wvs_ctrl import wvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACT_W-1:0] action,
	input  ctl_sts_t         sts,
	output ctl_cmd_t         cmd,
	output logic             busy
);

	localparam int SW = 4;
	localparam logic [SW-1:0] S_INIT = 4'd0;
	localparam logic [SW-1:0] S_IDLE = 4'd1;
	localparam logic [SW-1:0] S_CLR  = 4'd2;
	localparam logic [SW-1:0] S_LD1  = 4'd3;
	localparam logic [SW-1:0] S_LD2  = 4'd4;
	localparam logic [SW-1:0] S_LD3  = 4'd5;
	localparam logic [SW-1:0] S_BN1  = 4'd6;
	localparam logic [SW-1:0] S_BN2  = 4'd7;
	localparam logic [SW-1:0] S_BRUN = 4'd8;
	localparam logic [SW-1:0] S_BDRN = 4'd9;
	localparam logic [SW-1:0] S_BFIN = 4'd10;
	localparam logic [SW-1:0] S_S0   = 4'd11;
	localparam logic [SW-1:0] S_S1   = 4'd12;
	localparam logic [SW-1:0] S_S2   = 4'd13;
	localparam logic [SW-1:0] S_SRD  = 4'd14;
	localparam logic [SW-1:0] S_SCMP = 4'd15;

	logic [SW-1:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.cap      = 1'b1;
					cmd.cnt_zero = 1'b1;
					unique case (action)
						ACT_CLEAR:  state_d = S_CLR;
						ACT_LOAD:   state_d = S_LD1;
						ACT_BUILD:  state_d = S_BN1;
						ACT_SAMPLE: state_d = S_S0;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.unbuild  = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_PLAIN;
					state_d      = S_IDLE;
				end
			end
			S_LD1: begin
				cmd.ld_mul1 = 1'b1;
				state_d     = S_LD2;
			end
			S_LD2: begin
				cmd.ld_mul2 = 1'b1;
				state_d     = S_LD3;
			end
			S_LD3: begin
				cmd.ld_wr    = 1'b1;
				cmd.emit     = 1'b1;
				cmd.emit_sel = EM_LOAD;
				state_d      = S_IDLE;
			end
			S_BN1: begin
				cmd.n_mul1 = 1'b1;
				state_d    = S_BN2;
			end
			S_BN2: begin
				cmd.n_mul2 = 1'b1;
				state_d    = S_BRUN;
			end
			S_BRUN: begin
				if (sts.walk_done) begin
					state_d = S_BDRN;
				end else begin
					cmd.bld_step = 1'b1;
				end
			end
			S_BDRN: begin
				state_d = S_BFIN;
			end
			S_BFIN: begin
				cmd.bld_fin  = 1'b1;
				cmd.emit     = 1'b1;
				cmd.emit_sel = EM_PLAIN;
				state_d      = S_IDLE;
			end
			S_S0: begin
				if (sts.smp_ok) begin
					state_d = S_S1;
				end else begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_NOTBUILT;
					state_d      = S_IDLE;
				end
			end
			S_S1: begin
				cmd.smp_mul1 = 1'b1;
				state_d      = S_S2;
			end
			S_S2: begin
				cmd.smp_mul2 = 1'b1;
				state_d      = S_SRD;
			end
			S_SRD: begin
				if (sts.srch_done) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_SAMPLE;
					state_d      = S_IDLE;
				end else begin
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = S_SRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/wvs_datapath.sv
// Weight and cumulative stores, multipliers and search registers of the sampler.
module wvs_datapath import wvs_pkg::*; #(
	parameter int MAX_VOXELS  = DEF_MAX_VOXELS,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item,
	input  grid_cfg_t grid,
	input  ctl_cmd_t  cmd,
	output ctl_sts_t  sts,
	output logic      done,
	output result_t   result
);

	localparam int IDX_W   = $clog2(MAX_VOXELS);
	localparam int CNT_W   = $clog2(MAX_VOXELS + 1);
	localparam int SUM_W   = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;
	localparam int PROD1_W = 2 * GRID_W;
	localparam int NPROD_W = 3 * GRID_W;
	localparam int INNER_W = GRID_W + COORD_W + 1;
	localparam int LIDX_W  = GRID_W + INNER_W + 1;
	localparam int PLO_W   = 2 * RAND_W;
	localparam int THR_W   = TOTAL_W + 1;

	item_t item_q;

	logic [WEIGHT_BITS-1:0] wmem [MAX_VOXELS];
	logic [TOTAL_W-1:0]     cmem [MAX_VOXELS];

	logic [CNT_W-1:0]       cnt_q;
	logic                   w_we;
	logic [IDX_W-1:0]       w_wa;
	logic [WEIGHT_BITS-1:0] w_wd;
	logic [WEIGHT_BITS-1:0] w_rd_s1;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [SUM_W-1:0]       acc;
	logic [TOTAL_W-1:0]     sum_q, sum_nxt;

	logic [PROD1_W-1:0]     prod1_q;
	logic [NPROD_W-1:0]     nprod;
	logic [CNT_W-1:0]       vox_n_q, built_n_q;
	logic                   built_q;
	logic [TOTAL_W-1:0]     total_q;

	logic [INNER_W-1:0]     inner_q;
	logic                   rng_bad_q;
	logic [LIDX_W-1:0]      lidx_q;
	logic                   ld_ok;

	logic [PLO_W-1:0]       plo_q;
	logic [THR_W-1:0]       thr_sum;
	logic [TOTAL_W-1:0]     thr_q;
	logic [CNT_W-1:0]       lo_q, hi_q, mid, pick;
	logic [CNT_W:0]         mid_sum;
	logic [TOTAL_W-1:0]     c_rd_q;
	result_t                res_nxt;

	// weight store: clear sweep or load writes, build walk reads
	assign w_we = cmd.clr_step | (cmd.ld_wr & ld_ok);
	assign w_wa = cmd.clr_step ? cnt_q[IDX_W-1:0] : lidx_q[IDX_W-1:0];
	assign w_wd = cmd.clr_step ? '0 : WEIGHT_BITS'(item_q.weight);

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_wa] <= w_wd;
		end
		w_rd_s1 <= wmem[cnt_q[IDX_W-1:0]];
		idx_s1  <= cnt_q[IDX_W-1:0];
	end

	// saturating running sum
	assign acc     = SUM_W'(sum_q) + SUM_W'(w_rd_s1);
	assign sum_nxt = (acc > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];

	// binary search midpoint
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			cmem[idx_s1] <= sum_nxt;
		end
		c_rd_q <= cmem[mid[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			built_q   <= 1'b0;
			built_n_q <= '0;
			total_q   <= '0;
			done      <= 1'b0;
		end else begin
			if (cmd.cnt_zero) begin
				cnt_q <= '0;
			end else if (cmd.clr_step || cmd.bld_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= cmd.bld_step;
			if (cmd.bld_fin) begin
				built_q   <= 1'b1;
				built_n_q <= vox_n_q;
				total_q   <= sum_q;
			end else if (cmd.unbuild) begin
				built_q <= 1'b0;
			end
			done <= cmd.emit;
		end
	end

	assign nprod = NPROD_W'(prod1_q) * NPROD_W'(grid.grid_z);
	assign ld_ok = !rng_bad_q && (lidx_q < LIDX_W'(MAX_VOXELS));
	assign thr_sum = THR_W'(item_q.random_fraction) * THR_W'(total_q[TOTAL_W-1:RAND_W])
		+ THR_W'(plo_q[PLO_W-1:RAND_W]);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= item;
		end
		if (cmd.cnt_zero) begin
			sum_q <= '0;
		end else if (rd_vld_s1) begin
			sum_q <= sum_nxt;
		end
		if (cmd.n_mul1) begin
			prod1_q <= PROD1_W'(grid.grid_x) * PROD1_W'(grid.grid_y);
		end
		if (cmd.n_mul2) begin
			vox_n_q <= (nprod > NPROD_W'(MAX_VOXELS)) ? CNT_W'(MAX_VOXELS)
				: nprod[CNT_W-1:0];
		end
		if (cmd.ld_mul1) begin
			inner_q   <= INNER_W'(item_q.voxel_y)
				+ INNER_W'(grid.grid_y) * INNER_W'(item_q.voxel_z);
			rng_bad_q <= (GRID_W'(item_q.voxel_x) >= grid.grid_x)
				|| (GRID_W'(item_q.voxel_y) >= grid.grid_y)
				|| (GRID_W'(item_q.voxel_z) >= grid.grid_z);
		end
		if (cmd.ld_mul2) begin
			lidx_q <= LIDX_W'(item_q.voxel_x) + LIDX_W'(grid.grid_x) * LIDX_W'(inner_q);
		end
		if (cmd.smp_mul1) begin
			plo_q <= PLO_W'(item_q.random_fraction) * PLO_W'(total_q[RAND_W-1:0]);
		end
		if (cmd.smp_mul2) begin
			thr_q <= thr_sum[TOTAL_W-1:0];
			lo_q  <= '0;
			hi_q  <= built_n_q;
		end else if (cmd.srch_cmp) begin
			if (c_rd_q > thr_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + 1'b1;
			end
		end
		if (cmd.emit) begin
			result <= res_nxt;
		end
	end

	assign pick = (lo_q >= built_n_q) ? (built_n_q - 1'b1) : lo_q;

	always_comb begin
		res_nxt              = '0;
		res_nxt.total_weight = cmd.bld_fin ? sum_q : total_q;
		res_nxt.status       = ST_OK;
		unique case (cmd.emit_sel)
			EM_PLAIN:    res_nxt.status = ST_OK;
			EM_LOAD:     res_nxt.status = ld_ok ? ST_OK : ST_RANGE;
			EM_NOTBUILT: res_nxt.status = ST_NOTBUILT;
			EM_SAMPLE:   res_nxt.chosen_voxel = VOX_W'(pick);
			default:     res_nxt.status = ST_OK;
		endcase
	end

	assign sts.clr_last  = (cnt_q == CNT_W'(MAX_VOXELS - 1));
	assign sts.walk_done = (cnt_q >= vox_n_q);
	assign sts.smp_ok    = built_q && (total_q != '0) && (built_n_q != '0);
	assign sts.srch_done = (lo_q >= hi_q);

endmodule
